>>> hdl/dctcf_pkg.sv
package dctcf_pkg;

  localparam int COORD_WIDTH_DEFAULT = 32;
  localparam int RADIUS_WIDTH        = 31;
  localparam int FACE_WIDTH          = 3;

  localparam logic [FACE_WIDTH-1:0] FACE_POS_X = 3'd0;
  localparam logic [FACE_WIDTH-1:0] FACE_NEG_X = 3'd1;
  localparam logic [FACE_WIDTH-1:0] FACE_POS_Y = 3'd2;
  localparam logic [FACE_WIDTH-1:0] FACE_NEG_Y = 3'd3;
  localparam logic [FACE_WIDTH-1:0] FACE_POS_Z = 3'd4;
  localparam logic [FACE_WIDTH-1:0] FACE_NEG_Z = 3'd5;

endpackage

>>> hdl/dctcf_ifs.sv
interface dctcf_dir_if #(
  parameter int COORD_WIDTH = dctcf_pkg::COORD_WIDTH_DEFAULT
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] dir_x;
  logic signed [COORD_WIDTH-1:0] dir_y;
  logic signed [COORD_WIDTH-1:0] dir_z;

  modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
  modport sink   (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

interface dctcf_res_if #(
  parameter int COORD_WIDTH = dctcf_pkg::COORD_WIDTH_DEFAULT
);
  logic                                   valid;
  logic                                   ready;
  logic                                   valid_res;
  logic [dctcf_pkg::FACE_WIDTH-1:0]       face;
  logic signed [COORD_WIDTH-1:0]          face_u;
  logic signed [COORD_WIDTH-1:0]          face_v;

  modport source (output valid, output valid_res, output face, output face_u, output face_v,
                  input ready);
  modport sink   (input valid, input valid_res, input face, input face_u, input face_v,
                  output ready);
endinterface

>>> hdl/direction_to_cube_face_coords_core.sv
// Cube-map face selection: picks the face of a direction by its largest-magnitude
// component (ties to X, then Y, then Z) and returns radius*minor/|major| for the two
// minor components, truncated toward zero, with the per-face axis signs. A zero
// direction or zero radius yields valid_res = 0 with all fields zero. One word is
// accepted per cycle unless the output word is held. Stages A and B feed the scaled-ratio
// divider, which retires one radius bit per pipeline stage, then the output register. The
// whole pipeline holds while the output word waits. Write radius only while idle.
module direction_to_cube_face_coords_core #(
  parameter int COORD_WIDTH = dctcf_pkg::COORD_WIDTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                radius_we,
  input  logic [dctcf_pkg::RADIUS_WIDTH-1:0]  radius_wdata,
  dctcf_dir_if.sink                           dir_ch,
  dctcf_res_if.source                         res_ch
);
  import dctcf_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int RB = RADIUS_WIDTH;
  localparam int QW = (CW > RB) ? CW : RB;

  function automatic logic [CW+1:0] div_step(logic [CW-1:0] rem, logic [CW-1:0] a,
                                             logic [CW-1:0] m, logic rbit);
    logic [CW:0] t;
    logic [CW:0] mm;
    logic        c1;
    logic        c2;
    mm = {1'b0, m};
    t  = {rem, 1'b0};
    c1 = (t >= mm);
    if (c1) t = t - mm;
    c2 = 1'b0;
    if (rbit) begin
      t  = t + {1'b0, a};
      c2 = (t >= mm);
      if (c2) t = t - mm;
    end
    return {c1, c2, t[CW-1:0]};
  endfunction

  logic [RB-1:0] radius;
  logic          advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= '0;
    end else if (radius_we) begin
      radius <= radius_wdata;
    end
  end

  // stage A: magnitudes and signs
  logic          a_vld;
  logic [CW-1:0] a_ax, a_ay, a_az;
  logic          a_nx, a_ny, a_nz;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (advance) begin
      a_vld <= dir_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_nx <= dir_ch.dir_x[CW-1];
      a_ny <= dir_ch.dir_y[CW-1];
      a_nz <= dir_ch.dir_z[CW-1];
      a_ax <= dir_ch.dir_x[CW-1] ? (~dir_ch.dir_x + 1'b1) : dir_ch.dir_x;
      a_ay <= dir_ch.dir_y[CW-1] ? (~dir_ch.dir_y + 1'b1) : dir_ch.dir_y;
      a_az <= dir_ch.dir_z[CW-1] ? (~dir_ch.dir_z + 1'b1) : dir_ch.dir_z;
    end
  end

  // stage B: face select
  logic                  b_vld;
  logic                  b_ok;
  logic [FACE_WIDTH-1:0] b_face;
  logic [CW-1:0]         b_m, b_ua, b_va;
  logic                  b_un, b_vn;

  logic                  sel_ok;
  logic [FACE_WIDTH-1:0] sel_face;
  logic [CW-1:0]         sel_m, sel_ua, sel_va;
  logic                  sel_un, sel_vn;

  always_comb begin
    sel_ok = (radius != '0) && ((a_ax | a_ay | a_az) != '0);
    priority if ((a_ax >= a_ay) && (a_ax >= a_az)) begin
      sel_m    = a_ax;
      sel_face = a_nx ? FACE_NEG_X : FACE_POS_X;
      sel_ua   = a_ay;
      sel_un   = a_nx ? ~a_ny : a_ny;
      sel_va   = a_az;
      sel_vn   = a_nz;
    end else if (a_ay >= a_az) begin
      sel_m    = a_ay;
      sel_face = a_ny ? FACE_NEG_Y : FACE_POS_Y;
      sel_ua   = a_ax;
      sel_un   = a_ny ? a_nx : ~a_nx;
      sel_va   = a_az;
      sel_vn   = a_nz;
    end else begin
      sel_m    = a_az;
      sel_face = a_nz ? FACE_NEG_Z : FACE_POS_Z;
      sel_ua   = a_ax;
      sel_un   = a_nz ? ~a_nx : a_nx;
      sel_va   = a_ay;
      sel_vn   = a_ny;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (advance) begin
      b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      b_ok   <= sel_ok;
      b_face <= sel_face;
      b_m    <= sel_m;
      b_ua   <= sel_ua;
      b_va   <= sel_va;
      b_un   <= sel_un;
      b_vn   <= sel_vn;
    end
  end

  // divider stages: stage k retires radius bit RB-1-k
  logic                  d_vld  [RB];
  logic                  d_ok   [RB];
  logic [FACE_WIDTH-1:0] d_face [RB];
  logic [CW-1:0]         d_m    [RB];
  logic [CW-1:0]         d_ua   [RB];
  logic [CW-1:0]         d_va   [RB];
  logic                  d_un   [RB];
  logic                  d_vn   [RB];
  logic [RB-1:0]         d_qu   [RB];
  logic [RB-1:0]         d_qv   [RB];
  logic [CW-1:0]         d_ru   [RB];
  logic [CW-1:0]         d_rv   [RB];

  for (genvar k = 0; k < RB; k++) begin : g_div
    logic                  p_vld;
    logic                  p_ok;
    logic [FACE_WIDTH-1:0] p_face;
    logic [CW-1:0]         p_m, p_ua, p_va, p_ru, p_rv;
    logic                  p_un, p_vn;
    logic [RB-1:0]         p_qu, p_qv;
    logic [CW+1:0]         su, sv;

    if (k == 0) begin : g_first
      assign p_vld  = b_vld;
      assign p_ok   = b_ok;
      assign p_face = b_face;
      assign p_m    = b_m;
      assign p_ua   = b_ua;
      assign p_va   = b_va;
      assign p_un   = b_un;
      assign p_vn   = b_vn;
      assign p_qu   = '0;
      assign p_qv   = '0;
      assign p_ru   = '0;
      assign p_rv   = '0;
    end else begin : g_next
      assign p_vld  = d_vld[k-1];
      assign p_ok   = d_ok[k-1];
      assign p_face = d_face[k-1];
      assign p_m    = d_m[k-1];
      assign p_ua   = d_ua[k-1];
      assign p_va   = d_va[k-1];
      assign p_un   = d_un[k-1];
      assign p_vn   = d_vn[k-1];
      assign p_qu   = d_qu[k-1];
      assign p_qv   = d_qv[k-1];
      assign p_ru   = d_ru[k-1];
      assign p_rv   = d_rv[k-1];
    end

    assign su = div_step(p_ru, p_ua, p_m, radius[RB-1-k]);
    assign sv = div_step(p_rv, p_va, p_m, radius[RB-1-k]);

    always_ff @(posedge clk) begin
      if (rst) begin
        d_vld[k] <= 1'b0;
      end else if (advance) begin
        d_vld[k] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        d_ok[k]   <= p_ok;
        d_face[k] <= p_face;
        d_m[k]    <= p_m;
        d_ua[k]   <= p_ua;
        d_va[k]   <= p_va;
        d_un[k]   <= p_un;
        d_vn[k]   <= p_vn;
        d_ru[k]   <= su[CW-1:0];
        d_rv[k]   <= sv[CW-1:0];
        d_qu[k]   <= {p_qu[RB-2:0], 1'b0} + RB'({1'b0, su[CW+1]} + {1'b0, su[CW]});
        d_qv[k]   <= {p_qv[RB-2:0], 1'b0} + RB'({1'b0, sv[CW+1]} + {1'b0, sv[CW]});
      end
    end
  end

  // output stage
  logic                  o_vld;
  logic [QW-1:0]         qu_ext, qv_ext, cu, cv;

  assign qu_ext = QW'(d_qu[RB-1]);
  assign qv_ext = QW'(d_qv[RB-1]);
  assign cu     = d_un[RB-1] ? (QW'(0) - qu_ext) : qu_ext;
  assign cv     = d_vn[RB-1] ? (QW'(0) - qv_ext) : qv_ext;

  assign advance      = !o_vld || res_ch.ready;
  assign dir_ch.ready = advance;
  assign res_ch.valid = o_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
    end else if (advance) begin
      o_vld <= d_vld[RB-1];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_ch.valid_res <= d_ok[RB-1];
      res_ch.face      <= d_ok[RB-1] ? d_face[RB-1] : FACE_POS_X;
      res_ch.face_u    <= d_ok[RB-1] ? cu[CW-1:0] : '0;
      res_ch.face_v    <= d_ok[RB-1] ? cv[CW-1:0] : '0;
    end
  end

endmodule

>>> tb/testbench.sv
module testbench;
  import dctcf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW          = COORD_WIDTH_DEFAULT;
  localparam int RW          = RADIUS_WIDTH;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN       = 60;
  localparam int HOLD_PHASE  = 5;

  localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [RW-1:0]        R_MAX = '1;

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } dir_word_t;

  typedef struct packed {
    logic                  valid_res;
    logic [FACE_WIDTH-1:0] face;
    logic [CW-1:0]         face_u;
    logic [CW-1:0]         face_v;
  } face_word_t;

  logic          clk;
  logic          rst;
  logic          radius_we;
  logic [RW-1:0] radius_wdata;

  dctcf_dir_if #(.COORD_WIDTH(CW)) dir_ch ();
  dctcf_res_if #(.COORD_WIDTH(CW)) res_ch ();

  direction_to_cube_face_coords_core #(.COORD_WIDTH(CW)) dut (
    .clk          (clk),
    .rst          (rst),
    .radius_we    (radius_we),
    .radius_wdata (radius_wdata),
    .dir_ch       (dir_ch),
    .res_ch       (res_ch)
  );

  dir_word_t     pending[$];
  face_word_t    face_expect[$];
  logic [RW-1:0] radius_now;
  logic          dir_taken;
  bit            no_gaps;
  int            phase_tag;
  int            hold_left;
  bit            hold_done;
  int            bad_words;
  int            dirs_sent;
  int            words_checked;
  int            invalid_seen;
  int            radius_writes;
  bit [7:0]      faces_seen;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // exact integer projection onto the cube face
  function automatic face_word_t project_onto_cube(logic [RW-1:0] rad, logic signed [CW-1:0] x,
                                                   logic signed [CW-1:0] y,
                                                   logic signed [CW-1:0] z);
    face_word_t w;
    longint     r, sx, sy, sz, ax, ay, az, major, nu, nv;
    w  = '0;
    r  = longint'(rad);
    sx = longint'(x);
    sy = longint'(y);
    sz = longint'(z);
    ax = (sx < 0) ? -sx : sx;
    ay = (sy < 0) ? -sy : sy;
    az = (sz < 0) ? -sz : sz;
    if (r == 0 || (ax == 0 && ay == 0 && az == 0)) return w;
    w.valid_res = 1'b1;
    if (ax >= ay && ax >= az) begin
      major = ax;
      nv    = sz;
      if (sx < 0) begin
        w.face = FACE_NEG_X;
        nu     = -sy;
      end else begin
        w.face = FACE_POS_X;
        nu     = sy;
      end
    end else if (ay >= az) begin
      major = ay;
      nv    = sz;
      if (sy < 0) begin
        w.face = FACE_NEG_Y;
        nu     = sx;
      end else begin
        w.face = FACE_POS_Y;
        nu     = -sx;
      end
    end else begin
      major = az;
      nv    = sy;
      if (sz < 0) begin
        w.face = FACE_NEG_Z;
        nu     = -sx;
      end else begin
        w.face = FACE_POS_Z;
        nu     = sx;
      end
    end
    // signed division truncates toward zero
    w.face_u = CW'((r * nu) / major);
    w.face_v = CW'((r * nv) / major);
    return w;
  endfunction

  function automatic logic signed [CW-1:0] pick_coord();
    case ($urandom_range(11))
      0: return '0;
      1: return C_MIN;
      2: return C_MAX;
      3: return int'($urandom_range(40)) - 20;
      4: return int'($urandom >> $urandom_range(CW-1));
      5: return -int'($urandom >> $urandom_range(CW-1));
      default: return $urandom;
    endcase
  endfunction

  task automatic flag_mismatch(input string what);
    bad_words++;
    if (bad_words <= 10) $display("MISMATCH @%0t: %s", $time, what);
  endtask

  task automatic push_dir(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                          input logic signed [CW-1:0] z);
    dir_word_t d;
    d.x = x;
    d.y = y;
    d.z = z;
    pending.push_back(d);
  endtask

  task automatic push_random(input int n);
    dir_word_t d;
    repeat (n) begin
      d.x = pick_coord();
      d.y = pick_coord();
      d.z = pick_coord();
      // force magnitude ties now and then
      case ($urandom_range(7))
        0: d.y = $urandom_range(1) ? d.x : -d.x;
        1: d.z = $urandom_range(1) ? d.y : -d.y;
        2: d.z = $urandom_range(1) ? d.x : -d.x;
        3: begin
          d.y = $urandom_range(1) ? d.x : -d.x;
          d.z = $urandom_range(1) ? d.x : -d.x;
        end
        default: ;
      endcase
      pending.push_back(d);
    end
  endtask

  task automatic settle();
    while (pending.size() != 0 || dir_ch.valid || face_expect.size() != 0) @(negedge clk);
  endtask

  task automatic set_radius(input logic [RW-1:0] r);
    settle();
    radius_we    <= 1'b1;
    radius_wdata <= r;
    radius_now    = r;
    radius_writes++;
    @(negedge clk);
    radius_we <= 1'b0;
  endtask

  // driver
  always @(negedge clk) begin
    if (rst) begin
      dir_ch.valid <= 1'b0;
      dir_ch.dir_x <= '0;
      dir_ch.dir_y <= '0;
      dir_ch.dir_z <= '0;
    end else begin
      if (dir_taken) void'(pending.pop_front());
      if (!dir_ch.valid || dir_taken) begin
        if (pending.size() != 0 && (no_gaps || $urandom_range(99) >= 16)) begin
          dir_ch.valid <= 1'b1;
          dir_ch.dir_x <= pending[0].x;
          dir_ch.dir_y <= pending[0].y;
          dir_ch.dir_z <= pending[0].z;
        end else begin
          dir_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver backpressure, with one long hold-off to fill the pipeline
  always @(negedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      hold_left    <= 0;
      hold_done    <= 1'b0;
    end else if (hold_left > 0) begin
      res_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (phase_tag == HOLD_PHASE && !hold_done && dir_ch.valid) begin
      res_ch.ready <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      hold_done    <= 1'b1;
    end else begin
      res_ch.ready <= no_gaps || ($urandom_range(99) >= 16);
    end
  end

  // monitor
  always @(posedge clk) begin
    face_word_t want;
    if (rst) begin
      dir_taken <= 1'b0;
    end else begin
      dir_taken <= dir_ch.valid && dir_ch.ready;
      if (res_ch.valid && res_ch.ready) begin
        words_checked++;
        if (!res_ch.valid_res) invalid_seen++;
        else faces_seen[res_ch.face] = 1'b1;
        if (face_expect.size() == 0) begin
          flag_mismatch("result word with nothing expected");
        end else begin
          want = face_expect.pop_front();
          if (res_ch.valid_res !== want.valid_res || res_ch.face !== want.face ||
              res_ch.face_u !== want.face_u || res_ch.face_v !== want.face_v)
            flag_mismatch($sformatf(
              "exp ok=%0d face=%0d u=%0d v=%0d, got ok=%0d face=%0d u=%0d v=%0d",
              want.valid_res, want.face, $signed(want.face_u), $signed(want.face_v),
              res_ch.valid_res, res_ch.face, $signed(res_ch.face_u),
              $signed(res_ch.face_v)));
        end
      end
      if (dir_ch.valid && dir_ch.ready) begin
        dirs_sent++;
        face_expect.push_back(project_onto_cube(radius_now, dir_ch.dir_x, dir_ch.dir_y,
                                                dir_ch.dir_z));
      end
    end
  end

  initial begin
    #2ms;
    $display("timeout: %0d words still expected", face_expect.size());
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    rst           = 1'b1;
    radius_we     = 1'b0;
    radius_wdata  = '0;
    radius_now    = '0;
    no_gaps       = 1'b0;
    phase_tag     = 0;
    bad_words     = 0;
    dirs_sent     = 0;
    words_checked = 0;
    invalid_seen  = 0;
    radius_writes = 0;
    faces_seen    = '0;
    dir_ch.valid  = 1'b0;
    dir_ch.dir_x  = '0;
    dir_ch.dir_y  = '0;
    dir_ch.dir_z  = '0;
    res_ch.ready  = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // radius still at its reset value: everything invalid
    push_dir(1, 2, 3);
    push_dir(C_MIN, C_MIN, C_MIN);

    phase_tag = 1;
    set_radius(R_MAX);
    push_dir(0, 0, 0);
    push_dir(C_MIN, 0, 0);
    push_dir(C_MAX, C_MAX, C_MAX);
    push_dir(C_MIN, C_MIN, C_MIN);
    push_dir(0, C_MAX, 0);
    push_dir(0, C_MIN, 5);
    push_dir(3, -7, 100);
    push_dir(-3, 7, -100);
    push_dir(5, -5, 1);
    push_dir(-5, 5, 2);
    push_dir(1, 6, -6);
    push_dir(1, -6, 6);
    push_dir(C_MIN, C_MIN, 0);
    push_dir(C_MAX, C_MIN, 0);
    push_dir(0, 0, 1);
    push_dir(0, 0, -1);
    push_dir(1, -1, 0);
    push_dir(7, 3, -2);
    push_dir(-7, -3, 2);
    push_dir(C_MAX, C_MIN + 1, C_MIN);

    phase_tag = 2;
    set_radius(1);
    push_dir(1, 1, -1);
    push_dir(3, 2, -2);
    push_random(100);

    phase_tag = 3;
    set_radius(0);
    push_random(30);

    phase_tag = 4;
    set_radius(RW'($urandom));
    no_gaps = 1'b1;
    push_random(200);
    settle();
    no_gaps = 1'b0;

    phase_tag = HOLD_PHASE;
    set_radius(R_MAX);
    push_random(200);

    phase_tag = 6;
    set_radius(RW'($urandom_range(1000, 1)));
    push_random(120);

    settle();
    repeat (DRAIN) @(negedge clk);
    if (face_expect.size() != 0) flag_mismatch("expected words left over");

    $display("%0d directions in, %0d results checked (%0d invalid), %0d radius writes",
             dirs_sent, words_checked, invalid_seen, radius_writes);
    $display("faces hit mask %b, with a %0d-cycle output hold-off", faces_seen[5:0],
             HOLD_CYCLES);
    if (bad_words == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatching words", bad_words);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
